@@ src/trts_pkg.sv @@
`default_nettype none
package trts_pkg;

  localparam int unsigned Channels = 4;
  localparam int unsigned ChW      = 2;
  localparam int unsigned Rows     = 64;
  localparam int unsigned RowW     = 6;

  localparam logic [6:0] VolMax       = 7'd64;
  localparam logic [7:0] NoInstrument = 8'hFF;
  localparam logic [7:0] DefaultTicks = 8'd6;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CELL  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    NOTE_NONE = 2'd0,
    NOTE_NEW  = 2'd1,
    NOTE_CUT  = 2'd2,
    NOTE_OFF  = 2'd3
  } note_e;

  localparam logic [3:0] FxPorta     = 4'h3;
  localparam logic [3:0] FxVolSlide  = 4'hA;
  localparam logic [3:0] FxJump      = 4'hB;
  localparam logic [3:0] FxSetVol    = 4'hC;
  localparam logic [3:0] FxBreak     = 4'hD;
  localparam logic [3:0] FxSpeed     = 4'hF;

  localparam logic [1:0] RegInitSpeed = 2'd0;
  localparam logic [1:0] RegSeqLen    = 2'd1;
  localparam logic [1:0] RegInstCnt   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  // one channel's record
  typedef struct packed {
    logic [6:0] volume;
    logic [7:0] instrument;
    logic       held;
    logic [3:0] slide_up;
    logic [3:0] slide_down;
    logic [3:0] effect;
    logic [7:0] param;
  } chan_t;

  // job handed to the channel unit
  typedef struct packed {
    logic       do_tick;
    logic       do_cell;
    logic       do_start;
    logic       do_clear;
    logic       do_fx;
    logic       voice;
    logic [1:0] kind;
    logic [7:0] inst;
    logic [3:0] fx;
    logic [7:0] param;
    logic [7:0] inst_count;
  } job_t;

  // saturating slide from the memories
  function automatic logic [6:0] slide_mem(input logic [6:0] v, input logic [3:0] up,
                                           input logic [3:0] dn);
    logic [7:0] s;
    s = {1'b0, v} + {4'd0, up};
    if (up != 4'd0) begin
      slide_mem = (s > {1'b0, VolMax}) ? VolMax : s[6:0];
    end else if (dn != 4'd0) begin
      slide_mem = (v > {3'd0, dn}) ? v - {3'd0, dn} : 7'd0;
    end else begin
      slide_mem = v;
    end
  endfunction

endpackage
`default_nettype wire

@@ src/trts_chan_unit.sv @@
`default_nettype none
// Shared per-channel update: one channel record in, updated record out.
module trts_chan_unit (
  input  var trts_pkg::chan_t cur_i,
  input  var trts_pkg::job_t  job_i,
  output trts_pkg::chan_t     nxt_o
);
  trts_pkg::chan_t c;
  logic inst_ok, inst_some;

  always_comb begin
    c = cur_i;
    inst_ok   = job_i.inst < job_i.inst_count;
    inst_some = (job_i.inst != trts_pkg::NoInstrument) && inst_ok;
    if (job_i.do_start) begin
      c.slide_up   = 4'd0;
      c.slide_down = 4'd0;
      c.effect     = 4'd0;
      c.param      = 8'd0;
    end else if (job_i.do_tick) begin
      if (!job_i.voice) c.held = 1'b0;
      if (job_i.do_clear) begin
        c.effect = 4'd0;
        c.param  = 8'd0;
      end else if (job_i.do_fx) begin
        if (c.effect == trts_pkg::FxVolSlide) begin
          if (c.param[7:4] != 4'd0) c.slide_up = c.param[7:4];
          if (c.param[3:0] != 4'd0) c.slide_down = c.param[3:0];
          c.volume = trts_pkg::slide_mem(c.volume, c.slide_up, c.slide_down);
        end
        if (c.effect == trts_pkg::FxSetVol && c.param <= {1'b0, trts_pkg::VolMax})
          c.volume = c.param[6:0];
        c.volume = trts_pkg::slide_mem(c.volume, c.slide_up, c.slide_down);
      end
    end else if (job_i.do_cell) begin
      if (!job_i.voice) c.held = 1'b0;
      c.effect = job_i.fx;
      c.param  = job_i.param;
      case (job_i.kind)
        trts_pkg::NOTE_OFF: c.held = 1'b0;
        trts_pkg::NOTE_NEW: begin
          if (job_i.fx == trts_pkg::FxPorta && job_i.voice && c.held) begin
            if (inst_some) c.instrument = job_i.inst;
          end else begin
            if (inst_ok) c.instrument = job_i.inst;
            if (c.instrument < job_i.inst_count) begin
              c.held   = 1'b1;
              c.volume = trts_pkg::VolMax;
              if (job_i.fx == trts_pkg::FxSetVol && job_i.param <= {1'b0, trts_pkg::VolMax})
                c.volume = job_i.param[6:0];
            end
          end
        end
        trts_pkg::NOTE_NONE: begin
          if (inst_some) c.instrument = job_i.inst;
          if (job_i.fx == trts_pkg::FxSetVol && job_i.param <= {1'b0, trts_pkg::VolMax})
            c.volume = job_i.param[6:0];
          if (job_i.fx == trts_pkg::FxVolSlide) begin
            if (job_i.param[7:4] != 4'd0) c.slide_up = job_i.param[7:4];
            if (job_i.param[3:0] != 4'd0) c.slide_down = job_i.param[3:0];
          end
        end
        default: ;
      endcase
    end
    nxt_o = c;
  end
endmodule
`default_nettype wire

@@ src/tracker_row_tick_sequencer_core.sv @@
`default_nettype none
// Four-channel tracker sequencer (flow and volume). Send OP_START, then one tick request
// per tracker tick; when row_start_o is set, send that row's cells one per channel. A
// cell request taken while playing visits only the addressed channel record; every other
// request (tick, start, a cell while stopped, the unused operation) visits all four: the
// flow update is done as the request is taken, then one shared channel unit walks the
// channel records one per cycle, and the result is loaded into an output register.
// The next request may enter while that result waits; a finished walk holds until the
// previous result has been taken.
module tracker_row_tick_sequencer_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire  [1:0] cfg_index_i,
  input  wire  [7:0] cfg_data_i,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [1:0] operation_i,
  input  wire  [1:0] channel_i,
  input  wire  [1:0] note_kind_i,
  input  wire  [7:0] instrument_i,
  input  wire  [3:0] effect_i,
  input  wire  [7:0] param_i,
  input  wire  [3:0] voices_active_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic       playing_o,
  output logic [7:0] position_o,
  output logic [5:0] row_o,
  output logic [7:0] tick_o,
  output logic       row_start_o,
  output logic       song_end_o,
  output logic [7:0] speed_o,
  output logic [6:0] volume_ch0_o,
  output logic [6:0] volume_ch1_o,
  output logic [6:0] volume_ch2_o,
  output logic [6:0] volume_ch3_o
);
  trts_pkg::state_e state_q, state_d;
  logic [7:0] init_speed_q, seq_len_q, inst_cnt_q;
  logic [7:0] tick_q, pos_q, tpr_q;
  logic [5:0] row_q, brk_row_q;
  logic       run_q, brk_q;
  logic [8:0] jump_q;
  trts_pkg::chan_t chan_q [trts_pkg::Channels];
  logic [1:0] op_q, kind_q;
  logic [7:0] inst_q, param_q;
  logic [3:0] fx_q, voices_q;
  logic [1:0] idx_q;
  logic       fx_tick_q, clr_q, rs_q, se_q;
  logic       ov_q;
  logic       out_free;

  trts_pkg::job_t  job;
  trts_pkg::chan_t cur, nxt;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == trts_pkg::ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_free    = !ov_q || out_ready_i;

  wire in_fire = in_valid_i && in_ready_o;

  // flow update on entry
  logic [7:0] tick_inc;
  logic [8:0] pos_n;
  logic [5:0] row_n;
  logic [6:0] row_raw;
  logic [7:0] bcd;
  assign tick_inc = tick_q + 8'd1;
  assign bcd = {param_i[7:4], 3'd0} + {2'd0, param_i[7:4], 1'b0} + {4'd0, param_i[3:0]};

  // next row and position at the end of a row
  always_comb begin
    pos_n   = {1'b0, pos_q};
    row_raw = {1'b0, row_q} + 7'd1;
    if (brk_q) begin
      if (!jump_q[8]) pos_n = jump_q;
      else pos_n = pos_n + 9'd1;
      row_raw = {1'b0, brk_row_q};
    end
    row_n = row_raw[5:0];
    if (row_raw[6]) pos_n = pos_n + 9'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_speed_q <= trts_pkg::DefaultTicks;
      seq_len_q    <= 8'd1;
      inst_cnt_q   <= 8'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        trts_pkg::RegInitSpeed: init_speed_q <= cfg_data_i;
        trts_pkg::RegSeqLen:    seq_len_q    <= cfg_data_i;
        trts_pkg::RegInstCnt:   inst_cnt_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cur = chan_q[idx_q];
  always_comb begin
    job            = '0;
    job.do_start   = (op_q == trts_pkg::OP_START);
    job.do_tick    = (op_q == trts_pkg::OP_TICK);
    job.do_cell    = (op_q == trts_pkg::OP_CELL);
    job.do_clear   = clr_q;
    job.do_fx      = fx_tick_q;
    job.voice      = voices_q[idx_q];
    job.kind       = kind_q;
    job.inst       = inst_q;
    job.fx         = fx_q;
    job.param      = param_q;
    job.inst_count = inst_cnt_q;
  end

  trts_chan_unit u_chan (.cur_i(cur), .job_i(job), .nxt_o(nxt));

  always_comb begin
    state_d = state_q;
    case (state_q)
      trts_pkg::ST_IDLE: if (in_fire) state_d = trts_pkg::ST_WALK;
      trts_pkg::ST_WALK: begin
        if (op_q == trts_pkg::OP_CELL || idx_q == 2'd3) state_d = trts_pkg::ST_DONE;
      end
      // hold until the previous result has been taken
      trts_pkg::ST_DONE: if (out_free) state_d = trts_pkg::ST_IDLE;
      default: state_d = trts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trts_pkg::ST_IDLE;
      ov_q    <= 1'b0;
      tick_q  <= 8'd0; row_q <= 6'd0; pos_q <= 8'd0;
      tpr_q   <= trts_pkg::DefaultTicks;
      run_q   <= 1'b0; brk_q <= 1'b0; brk_row_q <= 6'd0;
      jump_q  <= 9'h100;
      for (int i = 0; i < int'(trts_pkg::Channels); i++) begin
        chan_q[i] <= '{volume: 7'd0, instrument: trts_pkg::NoInstrument, default: '0};
      end
      op_q <= trts_pkg::OP_NONE;
      kind_q <= 2'd0; inst_q <= 8'd0; fx_q <= 4'd0; param_q <= 8'd0; voices_q <= 4'd0;
      idx_q <= 2'd0; fx_tick_q <= 1'b0; clr_q <= 1'b0; rs_q <= 1'b0; se_q <= 1'b0;
      playing_o    <= 1'b0;
      position_o   <= 8'd0;
      row_o        <= 6'd0;
      tick_o       <= 8'd0;
      row_start_o  <= 1'b0;
      song_end_o   <= 1'b0;
      speed_o      <= 8'd0;
      volume_ch0_o <= 7'd0;
      volume_ch1_o <= 7'd0;
      volume_ch2_o <= 7'd0;
      volume_ch3_o <= 7'd0;
    end else begin
      state_q <= state_d;
      if (state_q == trts_pkg::ST_DONE && out_free) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      case (state_q)
        trts_pkg::ST_IDLE: if (in_fire) begin
          kind_q <= note_kind_i; inst_q <= instrument_i; fx_q <= effect_i;
          param_q <= param_i; voices_q <= voices_active_i;
          idx_q <= 2'd0; fx_tick_q <= 1'b0; clr_q <= 1'b0;
          rs_q <= 1'b0; se_q <= 1'b0;
          op_q <= trts_pkg::OP_NONE;
          if (operation_i == trts_pkg::OP_START) begin
            op_q <= trts_pkg::OP_START;
            run_q <= 1'b1; pos_q <= 8'd0; row_q <= 6'd0; tick_q <= 8'd0;
            brk_q <= 1'b0; brk_row_q <= 6'd0; jump_q <= 9'h100;
            tpr_q <= (init_speed_q != 8'd0) ? init_speed_q : trts_pkg::DefaultTicks;
            rs_q <= 1'b1;
          end else if (operation_i == trts_pkg::OP_TICK && run_q) begin
            op_q <= trts_pkg::OP_TICK;
            if (tick_inc < tpr_q) begin
              tick_q <= tick_inc;
              fx_tick_q <= 1'b1;
            end else begin
              tick_q <= 8'd0;
              if (brk_q) begin
                brk_q <= 1'b0;
                if (!jump_q[8]) jump_q <= 9'h100;
                brk_row_q <= 6'd0;
              end
              row_q <= row_n;
              pos_q <= pos_n[7:0];
              if (pos_n >= {1'b0, seq_len_q}) begin
                run_q <= 1'b0; se_q <= 1'b1;
              end else begin
                clr_q <= 1'b1; rs_q <= 1'b1;
              end
            end
          end else if (operation_i == trts_pkg::OP_CELL && run_q) begin
            op_q <= trts_pkg::OP_CELL;
            idx_q <= channel_i;
            if (effect_i == trts_pkg::FxJump) begin
              jump_q <= {1'b0, param_i}; brk_q <= 1'b1; brk_row_q <= 6'd0;
            end else if (effect_i == trts_pkg::FxBreak) begin
              brk_q <= 1'b1;
              brk_row_q <= (bcd >= 8'(trts_pkg::Rows)) ? 6'd0 : bcd[5:0];
            end else if (effect_i == trts_pkg::FxSpeed && param_i != 8'd0) begin
              tpr_q <= param_i;
            end
          end
        end
        trts_pkg::ST_WALK: begin
          if (op_q != trts_pkg::OP_NONE) chan_q[idx_q] <= nxt;
          idx_q <= idx_q + 2'd1;
        end
        trts_pkg::ST_DONE: if (out_free) begin
          playing_o   <= run_q;
          position_o  <= pos_q;
          row_o       <= row_q;
          tick_o      <= tick_q;
          row_start_o <= rs_q;
          song_end_o  <= se_q;
          speed_o     <= tpr_q;
          volume_ch0_o <= chan_q[0].volume;
          volume_ch1_o <= chan_q[1].volume;
          volume_ch2_o <= chan_q[2].volume;
          volume_ch3_o <= chan_q[3].volume;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ test/tb_tracker_row_tick_sequencer_core.sv @@
`timescale 1ns / 100ps
module tb_tracker_row_tick_sequencer_core;
  import trts_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] ch;
    logic [1:0] kind;
    logic [7:0] inst;
    logic [3:0] fx;
    logic [7:0] prm;
    logic [3:0] voices;
  } cell_req_t;

  typedef struct packed {
    logic            playing;
    logic [7:0]      pos;
    logic [5:0]      row;
    logic [7:0]      tick;
    logic            row_start;
    logic            song_end;
    logic [7:0]      speed;
    logic [3:0][6:0] vol;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [1:0] operation = '0, channel = '0, note_kind = '0;
  logic [7:0] instrument = '0, param = '0;
  logic [3:0] effect = '0, voices_active = '0;
  logic out_ready = 1'b0;
  logic cfg_ready_o, in_ready_o, out_valid_o, playing_o, row_start_o, song_end_o;
  logic [7:0] position_o, tick_o, speed_o;
  logic [5:0] row_o;
  logic [6:0] volume_ch0_o, volume_ch1_o, volume_ch2_o, volume_ch3_o;

  tracker_row_tick_sequencer_core dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o, .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o,
    .operation_i(operation), .channel_i(channel), .note_kind_i(note_kind),
    .instrument_i(instrument), .effect_i(effect), .param_i(param),
    .voices_active_i(voices_active),
    .out_valid_o, .out_ready_i(out_ready),
    .playing_o, .position_o, .row_o, .tick_o, .row_start_o, .song_end_o, .speed_o,
    .volume_ch0_o, .volume_ch1_o, .volume_ch2_o, .volume_ch3_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cell_req_t pending_reqs[$];
  status_t   status_q[$];
  int unsigned errors = 0, reqs_sent = 0, statuses_seen = 0, song_ends = 0, cycles = 0;
  logic calm = 1'b0;

  // shadow of the registers and of the sequencer state
  int unsigned sh_speed = 6, sh_seq_len = 1, sh_inst_cnt = 0;
  int unsigned tick_cnt = 0, row_idx = 0, order_pos = 0, tpr = 6;
  int unsigned running = 0, brk = 0, brk_row = 0, jump = 256;
  int unsigned vol[4] = '{0, 0, 0, 0}, inst_ch[4] = '{255, 255, 255, 255};
  int unsigned held[4] = '{0, 0, 0, 0}, sup[4] = '{0, 0, 0, 0}, sdn[4] = '{0, 0, 0, 0};
  int unsigned fxs[4] = '{0, 0, 0, 0}, prm[4] = '{0, 0, 0, 0};

  task automatic slide_vol(int unsigned c);
    if (sup[c] > 0) vol[c] = (vol[c] + sup[c] > 64) ? 64 : vol[c] + sup[c];
    else if (sdn[c] > 0) vol[c] = (vol[c] > sdn[c]) ? vol[c] - sdn[c] : 0;
  endtask

  task automatic load_slides(int unsigned c, int unsigned p);
    if ((p >> 4) > 0) sup[c] = p >> 4;
    if ((p & 'h0F) > 0) sdn[c] = p & 'h0F;
  endtask

  task automatic advance_sequencer(cell_req_t r);
    status_t s;
    int unsigned c, pos, rr, act;
    s = '0;
    if (r.op == OP_START) begin
      running = 1; order_pos = 0; row_idx = 0; tick_cnt = 0;
      brk = 0; brk_row = 0; jump = 256;
      tpr = sh_speed ? sh_speed : 6;
      for (c = 0; c < 4; c++) begin
        sup[c] = 0; sdn[c] = 0; fxs[c] = 0; prm[c] = 0;
      end
      s.row_start = 1'b1;
    end else if (r.op == OP_TICK && running) begin
      for (c = 0; c < 4; c++) if (!r.voices[c]) held[c] = 0;
      tick_cnt++;
      if (tick_cnt < tpr) begin
        for (c = 0; c < 4; c++) begin
          if (fxs[c] == FxVolSlide) begin
            load_slides(c, prm[c]);
            slide_vol(c);
          end
          if (fxs[c] == FxSetVol && prm[c] <= 64) vol[c] = prm[c];
          slide_vol(c);
        end
      end else begin
        pos = order_pos;
        tick_cnt = 0;
        if (brk) begin
          brk = 0;
          if (jump < 256) begin
            pos = jump; jump = 256;
          end else begin
            pos++;
          end
          row_idx = brk_row; brk_row = 0;
        end else begin
          row_idx++;
        end
        if (row_idx >= 64) begin
          row_idx = 0; pos++;
        end
        order_pos = pos & 'hFF;
        if (pos >= sh_seq_len) begin
          running = 0; s.song_end = 1'b1;
        end else begin
          for (c = 0; c < 4; c++) begin
            fxs[c] = 0; prm[c] = 0;
          end
          s.row_start = 1'b1;
        end
      end
    end else if (r.op == OP_CELL && running) begin
      c = r.ch;
      act = r.voices[c];
      if (!act) held[c] = 0;
      fxs[c] = r.fx; prm[c] = r.prm;
      if (r.kind == NOTE_OFF) begin
        held[c] = 0;
      end else if (r.kind == NOTE_NEW) begin
        if (r.fx == FxPorta && act && held[c]) begin
          if (r.inst != NoInstrument && r.inst < sh_inst_cnt) inst_ch[c] = r.inst;
        end else begin
          if (r.inst < sh_inst_cnt) inst_ch[c] = r.inst;
          if (inst_ch[c] < sh_inst_cnt) begin
            held[c] = 1; vol[c] = 64;
            if (r.fx == FxSetVol && r.prm <= 64) vol[c] = r.prm;
          end
        end
      end else if (r.kind == NOTE_NONE) begin
        if (r.inst != NoInstrument && r.inst < sh_inst_cnt) inst_ch[c] = r.inst;
        if (r.fx == FxSetVol && r.prm <= 64) vol[c] = r.prm;
        if (r.fx == FxVolSlide) load_slides(c, r.prm);
      end
      if (r.fx == FxJump) begin
        jump = r.prm; brk = 1; brk_row = 0;
      end else if (r.fx == FxBreak) begin
        rr = r.prm[7:4] * 10 + r.prm[3:0];
        brk = 1; brk_row = (rr >= 64) ? 0 : rr;
      end else if (r.fx == FxSpeed) begin
        if (r.prm > 0) tpr = r.prm;
      end
    end
    s.playing = running[0];
    s.pos = order_pos[7:0];
    s.row = row_idx[5:0];
    s.tick = tick_cnt[7:0];
    s.speed = tpr[7:0];
    for (c = 0; c < 4; c++) s.vol[c] = vol[c][6:0];
    status_q.push_back(s);
  endtask

  // request driver
  cell_req_t cur_req;
  int unsigned in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        advance_sequencer(cur_req);
        reqs_sent++;
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 13);
      end
      if (!in_valid || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          operation <= cur_req.op;
          channel <= cur_req.ch;
          note_kind <= cur_req.kind;
          instrument <= cur_req.inst;
          effect <= cur_req.fx;
          param <= cur_req.prm;
          voices_active <= cur_req.voices;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // status monitor
  int unsigned out_gap = 0;
  always @(posedge clk_i) begin
    status_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        statuses_seen++;
        if (status_q.size() == 0) begin
          $display("%0t: status with none expected, expected none actual pos %0d", $time,
                   position_o);
          errors++;
        end else begin
          e = status_q.pop_front();
          if (e.song_end) song_ends++;
          check_field("playing", e.playing, playing_o);
          check_field("position", e.pos, position_o);
          check_field("row", e.row, row_o);
          check_field("tick", e.tick, tick_o);
          check_field("row_start", e.row_start, row_start_o);
          check_field("song_end", e.song_end, song_end_o);
          check_field("speed", e.speed, speed_o);
          check_field("volume_ch0", e.vol[0], volume_ch0_o);
          check_field("volume_ch1", e.vol[1], volume_ch1_o);
          check_field("volume_ch2", e.vol[2], volume_ch2_o);
          check_field("volume_ch3", e.vol[3], volume_ch3_o);
        end
      end
      if (out_gap > 0) out_gap--;
      else if (!calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 13);
      out_ready <= (out_gap == 0);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic cell_req_t mk(logic [1:0] op, logic [1:0] ch, logic [1:0] kind,
                                   logic [7:0] inst, logic [3:0] fx, logic [7:0] p,
                                   logic [3:0] v);
    mk = '{op: op, ch: ch, kind: kind, inst: inst, fx: fx, prm: p, voices: v};
  endfunction

  function automatic cell_req_t rnd_cell(logic [1:0] ch);
    cell_req_t r;
    r = mk(OP_CELL, ch, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 20)),
           4'($urandom), 8'($urandom), 4'd15);
    if ($urandom_range(0, 2) == 0) r.kind = NOTE_NEW;
    if ($urandom_range(0, 4) == 0) r.inst = ($urandom_range(0, 1)) ? NoInstrument : 8'($urandom);
    if ($urandom_range(0, 3) == 0) r.voices = 4'($urandom);
    case ($urandom_range(0, 9))
      0: r.fx = 4'h0;
      1: r.fx = FxPorta;
      2: r.fx = FxVolSlide;
      3: begin
        r.fx = FxJump;
        if ($urandom_range(0, 3) != 0) r.prm = 8'($urandom_range(0, 4));
      end
      4: begin
        r.fx = FxSetVol;
        if ($urandom_range(0, 3) != 0) r.prm = 8'($urandom_range(0, 70));
      end
      5: r.fx = FxBreak;
      6: begin
        r.fx = FxSpeed;
        if ($urandom_range(0, 9) != 0) r.prm = 8'($urandom_range(0, 4));
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic fill_song(int unsigned n);
    int unsigned k, j, t;
    pending_reqs.push_back(mk(OP_START, 2'($urandom), 0, 0, 0, 0, 4'($urandom)));
    k = 1;
    while (k < n) begin
      for (j = 0; j < 4; j++) pending_reqs.push_back(rnd_cell(2'(j)));
      t = $urandom_range(1, 6);
      for (j = 0; j < t; j++)
        pending_reqs.push_back(mk(OP_TICK, 2'($urandom), 2'($urandom), 8'($urandom),
                                  4'($urandom), 8'($urandom),
                                  ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'd15));
      k += 4 + t;
      case ($urandom_range(0, 9))
        0: pending_reqs.push_back(mk(OP_NONE, 2'($urandom), 2'($urandom), 8'($urandom),
                                     4'($urandom), 8'($urandom), 4'($urandom)));
        1: pending_reqs.push_back(rnd_cell(2'($urandom)));
        2: pending_reqs.push_back(mk(OP_START, 0, 0, 0, 0, 0, 4'd15));
        default: ;
      endcase
    end
  endtask

  task automatic settle();
    wait (pending_reqs.size() == 0 && !in_valid && status_q.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      RegInitSpeed: sh_speed = val;
      RegSeqLen:    sh_seq_len = val;
      default:      sh_inst_cnt = val;
    endcase
  endtask

  task automatic set_regs(logic [7:0] spd, logic [7:0] len, logic [7:0] cnt);
    settle();
    write_reg(RegInitSpeed, spd);
    write_reg(RegSeqLen, len);
    write_reg(RegInstCnt, cnt);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // idle requests and a short song on the reset settings
    pending_reqs.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 4'd0));
    pending_reqs.push_back(mk(OP_CELL, 1, NOTE_NEW, 8'd0, FxSetVol, 8'd10, 4'd15));
    pending_reqs.push_back(mk(OP_NONE, 3, 3, 8'hFF, 4'hF, 8'hFF, 4'd15));
    pending_reqs.push_back(mk(OP_START, 0, 0, 0, 0, 0, 4'd15));
    pending_reqs.push_back(mk(OP_CELL, 0, NOTE_NEW, 8'd0, FxSetVol, 8'd20, 4'd15));
    repeat (7) pending_reqs.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 4'd15));
    set_regs(8'd2, 8'd4, 8'd8);
    pending_reqs.push_back(mk(OP_START, 0, 0, 0, 0, 0, 4'd15));
    pending_reqs.push_back(mk(OP_CELL, 0, NOTE_NEW, 8'd1, FxSetVol, 8'd64, 4'd15));
    pending_reqs.push_back(mk(OP_CELL, 1, NOTE_NEW, 8'd2, FxVolSlide, 8'h3F, 4'd15));
    pending_reqs.push_back(mk(OP_CELL, 2, NOTE_OFF, 8'hFF, FxBreak, 8'h99, 4'd15));
    pending_reqs.push_back(mk(OP_CELL, 3, NOTE_NEW, 8'd9, FxSpeed, 8'd0, 4'd15));
    pending_reqs.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 4'd15));
    pending_reqs.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 4'b1101));
    pending_reqs.push_back(mk(OP_CELL, 0, NOTE_NEW, 8'd5, FxPorta, 8'd0, 4'd15));
    pending_reqs.push_back(mk(OP_CELL, 1, NOTE_NONE, 8'd3, FxVolSlide, 8'hF0, 4'd15));
    pending_reqs.push_back(mk(OP_CELL, 2, NOTE_CUT, 8'd7, FxJump, 8'd2, 4'd0));
    pending_reqs.push_back(mk(OP_CELL, 3, NOTE_NONE, 8'hFF, FxSetVol, 8'd65, 4'd15));
    repeat (3) pending_reqs.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 4'd15));
    pending_reqs.push_back(mk(OP_CELL, 0, NOTE_NONE, 8'd0, FxBreak, 8'h63, 4'd15));
    pending_reqs.push_back(mk(OP_CELL, 1, NOTE_NEW, 8'd2, FxSpeed, 8'hFF, 4'd15));
    repeat (2) pending_reqs.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 4'd15));
    fill_song(70);
    set_regs(8'd0, 8'd0, 8'd0);
    fill_song(60);
    set_regs(8'd255, 8'd255, 8'd255);
    fill_song(80);
    set_regs(8'd1, 8'd1, 8'd16);
    fill_song(80);
    set_regs(8'($urandom_range(1, 4)), 8'($urandom_range(2, 4)), 8'($urandom_range(4, 20)));
    calm = 1'b1;
    fill_song(80);
    settle();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d statuses, %0d song ends, %0d mismatches",
             reqs_sent, statuses_seen, song_ends, errors);
    $display("Covered idle and unused requests, flow effects, slides and five settings");
    if (errors == 0 && status_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/trts_pkg.sv
src/trts_chan_unit.sv
src/tracker_row_tick_sequencer_core.sv
test/tb_tracker_row_tick_sequencer_core.sv
